// ===== rtl/lod_level_select_dither_top_assert.svh =====
// ---------------------------------------------------------------------------
// LOD select assertion macros
// Concurrent assertion wrappers, compiled out with NO_ASSERTIONS.
// ---------------------------------------------------------------------------
`ifndef LOD_LEVEL_SELECT_DITHER_TOP_ASSERT_SVH
`define LOD_LEVEL_SELECT_DITHER_TOP_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define LODSEL_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("lodsel assertion failed");
`define LODSEL_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("lodsel assertion failed");
`else
`define LODSEL_ASSERT(label, clk, rst, prop)
`define LODSEL_ASSERT_ALWAYS(label, clk, prop)
`endif
`endif

// ===== rtl/lodsel_pkg.sv =====
// ---------------------------------------------------------------------------
// LOD select package
// Shared types, widths and constants of the LOD level selector.
// ---------------------------------------------------------------------------
package lodsel_pkg;

   localparam int FRAC_BITS = 16;

   localparam int COORD_W = 32;
   localparam int SQ_W    = 64;
   localparam int ROOT_W  = SQ_W / 2;
   localparam int DEPTH_W = 36;
   localparam int NUM_W   = 64;
   localparam int QUO_W   = 32;
   localparam int HASH_HI_W = 24;

   localparam int FRONT_STAGES = 4;
   localparam int LATENCY = FRONT_STAGES + ROOT_W + 1 + QUO_W + 2;

   localparam longint MIN_SPAN_RAW = ((64'd1 << FRAC_BITS) + 64'd500) / 64'd1000;
   localparam logic [31:0] MIN_SPAN = (MIN_SPAN_RAW != 0) ? 32'(MIN_SPAN_RAW) : 32'd1;

   localparam logic [31:0] FOCAL_RESET = 32'(64'd1 << FRAC_BITS);
   localparam logic [31:0] CULL_RESET  = 32'(64'd1 << FRAC_BITS);
   localparam logic [31:0] NEAR_RESET  = 32'd6554;

   localparam logic [31:0] HASH_GOLDEN = 32'h9e3779b9;
   localparam logic [31:0] HASH_MUL1   = 32'h7feb352d;
   localparam logic [31:0] HASH_MUL2   = 32'h846ca68b;

   typedef enum logic [1:0] {
      LEVEL_CULLED = 2'd0,
      LEVEL_PROXY  = 2'd1,
      LEVEL_FULL   = 2'd2
   } level_type;

   typedef enum logic [2:0] {
      CSR_FORWARD_DIR = 3'd0,
      CSR_EYE_DEPTH   = 3'd1,
      CSR_FOCAL_PX    = 3'd2,
      CSR_NEAR_PLANE  = 3'd3,
      CSR_CULL_PX     = 3'd4,
      CSR_FULL_BAND   = 3'd5,
      CSR_DITHER_SEED = 3'd6,
      CSR_LOD_MODE    = 3'd7
   } csr_index_type;

   typedef struct packed {
      logic                 keep_full;
      logic [HASH_HI_W-1:0] hash_hi;
      logic [DEPTH_W-1:0]   depth;
   } side_type;

endpackage

// ===== rtl/lodsel_front.sv =====
// ---------------------------------------------------------------------------
// LOD select front end
// Half extents, squared radius, view depth clamp and dither hash.
// ---------------------------------------------------------------------------
module lodsel_front (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        in_valid,
   input  logic [31:0]                 min_x,
   input  logic [31:0]                 min_y,
   input  logic [31:0]                 min_z,
   input  logic [31:0]                 max_x,
   input  logic [31:0]                 max_y,
   input  logic [31:0]                 max_z,
   input  logic [31:0]                 mesh_id,
   input  logic [31:0]                 placement_index,
   input  logic                        keep_full,
   input  logic [47:0]                 forward_dir,
   input  logic [31:0]                 eye_depth,
   input  logic [31:0]                 near_plane,
   input  logic [31:0]                 dither_seed,
   output logic                        out_valid,
   output logic [lodsel_pkg::SQ_W-1:0] out_dsq,
   output lodsel_pkg::side_type        out_side
);
   import lodsel_pkg::*;

   logic signed [31:0] mn [3];
   logic signed [31:0] mx [3];
   logic signed [32:0] diff [3];
   logic        [32:0] adiff [3];
   logic        [30:0] ext_in [3];
   logic signed [32:0] csum_in [3];
   logic        [31:0] key_in;

   logic        [30:0] ext_ff [3];
   logic signed [32:0] csum_ff [3];
   logic        [31:0] key_ff;
   logic               keep1_ff;
   logic               v1_ff;

   logic        [61:0] sq_in [3];
   logic signed [48:0] prod_in [3];
   logic        [31:0] hm1_in;
   logic        [61:0] sq_ff [3];
   logic signed [48:0] prod_ff [3];
   logic        [31:0] hm1_ff;
   logic               keep2_ff;
   logic               v2_ff;

   logic [SQ_W-1:0]    dsq_in;
   logic signed [50:0] dot_in;
   logic [31:0]        hm2_in;
   logic [SQ_W-1:0]    dsq_ff;
   logic signed [50:0] dot_ff;
   logic [31:0]        hm2_ff;
   logic               keep3_ff;
   logic               v3_ff;

   logic signed [34:0]        dsh;
   logic signed [DEPTH_W-1:0] depth_s;
   logic [31:0]               nearv;
   logic [31:0]               hfin;
   side_type                  side_in;
   side_type                  side_ff;
   logic [SQ_W-1:0]           dsq4_ff;
   logic                      v4_ff;

   assign mn[0] = min_x;
   assign mn[1] = min_y;
   assign mn[2] = min_z;
   assign mx[0] = max_x;
   assign mx[1] = max_y;
   assign mx[2] = max_z;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         diff[i]    = 33'(mx[i]) - 33'(mn[i]);
         adiff[i]   = diff[i][32] ? 33'(-diff[i]) : 33'(diff[i]);
         ext_in[i]  = adiff[i][31:1];
         csum_in[i] = 33'(mx[i]) + 33'(mn[i]);
      end
      key_in = (mesh_id * HASH_GOLDEN) ^ (placement_index + 32'd1) ^ dither_seed;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else begin
         v1_ff <= in_valid;
      end
      ext_ff   <= ext_in;
      csum_ff  <= csum_in;
      key_ff   <= key_in;
      keep1_ff <= keep_full;
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         sq_in[i]   = 62'(ext_ff[i]) * 62'(ext_ff[i]);
         prod_in[i] = 49'(csum_ff[i]) * 49'($signed(forward_dir[16*i +: 16]));
      end
      hm1_in = (key_ff ^ (key_ff >> 16)) * HASH_MUL1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else begin
         v2_ff <= v1_ff;
      end
      sq_ff    <= sq_in;
      prod_ff  <= prod_in;
      hm1_ff   <= hm1_in;
      keep2_ff <= keep1_ff;
   end

   always_comb begin
      dsq_in = SQ_W'(sq_ff[0]) + SQ_W'(sq_ff[1]) + SQ_W'(sq_ff[2]);
      dot_in = 51'(prod_ff[0]) + 51'(prod_ff[1]) + 51'(prod_ff[2]);
      hm2_in = (hm1_ff ^ (hm1_ff >> 15)) * HASH_MUL2;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else begin
         v3_ff <= v2_ff;
      end
      dsq_ff   <= dsq_in;
      dot_ff   <= dot_in;
      hm2_ff   <= hm2_in;
      keep3_ff <= keep2_ff;
   end

   always_comb begin
      dsh     = 35'(dot_ff >>> 16);
      depth_s = DEPTH_W'(dsh) - DEPTH_W'($signed(eye_depth));
      nearv   = (near_plane != 32'd0) ? near_plane : 32'd1;
      hfin    = hm2_ff ^ (hm2_ff >> 16);
      side_in.keep_full = keep3_ff;
      side_in.hash_hi   = hfin[31:8];
      if (depth_s < $signed({{(DEPTH_W-32){1'b0}}, nearv})) begin
         side_in.depth = {{(DEPTH_W-32){1'b0}}, nearv};
      end else begin
         side_in.depth = depth_s;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
      end else begin
         v4_ff <= v3_ff;
      end
      dsq4_ff <= dsq_ff;
      side_ff <= side_in;
   end

   assign out_valid = v4_ff;
   assign out_dsq   = dsq4_ff;
   assign out_side  = side_ff;

endmodule

// ===== rtl/lodsel_isqrt.sv =====
// ---------------------------------------------------------------------------
// LOD select square root
// Pipelined integer square root, one result bit per stage.
// ---------------------------------------------------------------------------
module lodsel_isqrt (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   input  logic [lodsel_pkg::SQ_W-1:0]   in_value,
   input  lodsel_pkg::side_type          in_side,
   output logic                          out_valid,
   output logic [lodsel_pkg::ROOT_W-1:0] out_root,
   output lodsel_pkg::side_type          out_side
);
   import lodsel_pkg::*;

   localparam int REM_W = ROOT_W + 4;

   logic [REM_W-1:0]  rem_ff  [ROOT_W];
   logic [ROOT_W-1:0] root_ff [ROOT_W];
   logic [SQ_W-1:0]   val_ff  [ROOT_W];
   side_type          side_ff [ROOT_W];
   logic              v_ff    [ROOT_W];

   for (genvar s = 0; s < ROOT_W; s++) begin : g_stage
      logic [REM_W-1:0]  rem_prev;
      logic [ROOT_W-1:0] root_prev;
      logic [SQ_W-1:0]   val_prev;
      side_type          side_prev;
      logic              v_prev;
      logic [REM_W-1:0]  rem_sh;
      logic [REM_W-1:0]  trial;
      logic [REM_W-1:0]  rem_in;
      logic [ROOT_W-1:0] root_in;

      if (s == 0) begin : g_first
         assign rem_prev  = '0;
         assign root_prev = '0;
         assign val_prev  = in_value;
         assign side_prev = in_side;
         assign v_prev    = in_valid;
      end else begin : g_next
         assign rem_prev  = rem_ff[s-1];
         assign root_prev = root_ff[s-1];
         assign val_prev  = val_ff[s-1];
         assign side_prev = side_ff[s-1];
         assign v_prev    = v_ff[s-1];
      end

      always_comb begin
         rem_sh = {rem_prev[REM_W-3:0], val_prev[SQ_W-1 -: 2]};
         trial  = REM_W'({root_prev, 2'b01});
         if (rem_sh >= trial) begin
            rem_in  = rem_sh - trial;
            root_in = {root_prev[ROOT_W-2:0], 1'b1};
         end else begin
            rem_in  = rem_sh;
            root_in = {root_prev[ROOT_W-2:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[s] <= 1'b0;
         end else begin
            v_ff[s] <= v_prev;
         end
         rem_ff[s]  <= rem_in;
         root_ff[s] <= root_in;
         val_ff[s]  <= {val_prev[SQ_W-3:0], 2'b00};
         side_ff[s] <= side_prev;
      end
   end

   assign out_valid = v_ff[ROOT_W-1];
   assign out_root  = root_ff[ROOT_W-1];
   assign out_side  = side_ff[ROOT_W-1];

endmodule

// ===== rtl/lodsel_div.sv =====
// ---------------------------------------------------------------------------
// LOD select divider
// Pipelined restoring divide with saturation, one quotient bit per stage.
// ---------------------------------------------------------------------------
module lodsel_div (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           in_valid,
   input  logic [lodsel_pkg::NUM_W-1:0]   in_num,
   input  lodsel_pkg::side_type           in_side,
   output logic                           out_valid,
   output logic [lodsel_pkg::QUO_W-1:0]   out_quo,
   output lodsel_pkg::side_type           out_side
);
   import lodsel_pkg::*;

   localparam int LOW_W = NUM_W - QUO_W;

   logic [DEPTH_W-1:0] rem_ff [QUO_W];
   logic [QUO_W-1:0]   quo_ff [QUO_W];
   logic [LOW_W-1:0]   low_ff [QUO_W];
   logic               sat_ff [QUO_W];
   side_type           side_ff [QUO_W];
   logic               v_ff [QUO_W];

   for (genvar s = 0; s < QUO_W; s++) begin : g_stage
      logic [DEPTH_W-1:0] rem_prev;
      logic [QUO_W-1:0]   quo_prev;
      logic [LOW_W-1:0]   low_prev;
      logic               sat_prev;
      side_type           side_prev;
      logic               v_prev;
      logic [DEPTH_W:0]   rem_sh;
      logic [DEPTH_W:0]   dvs;
      logic [DEPTH_W-1:0] rem_in;
      logic [QUO_W-1:0]   quo_in;

      if (s == 0) begin : g_first
         assign rem_prev  = DEPTH_W'(in_num[NUM_W-1:LOW_W]);
         assign quo_prev  = '0;
         assign low_prev  = in_num[LOW_W-1:0];
         assign sat_prev  = DEPTH_W'(in_num[NUM_W-1:LOW_W]) >= in_side.depth;
         assign side_prev = in_side;
         assign v_prev    = in_valid;
      end else begin : g_next
         assign rem_prev  = rem_ff[s-1];
         assign quo_prev  = quo_ff[s-1];
         assign low_prev  = low_ff[s-1];
         assign sat_prev  = sat_ff[s-1];
         assign side_prev = side_ff[s-1];
         assign v_prev    = v_ff[s-1];
      end

      always_comb begin
         rem_sh = {rem_prev, low_prev[LOW_W-1]};
         dvs    = {1'b0, side_prev.depth};
         if (rem_sh >= dvs) begin
            rem_in = DEPTH_W'(rem_sh - dvs);
            quo_in = {quo_prev[QUO_W-2:0], 1'b1};
         end else begin
            rem_in = DEPTH_W'(rem_sh);
            quo_in = {quo_prev[QUO_W-2:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[s] <= 1'b0;
         end else begin
            v_ff[s] <= v_prev;
         end
         rem_ff[s]  <= rem_in;
         quo_ff[s]  <= quo_in;
         low_ff[s]  <= {low_prev[LOW_W-2:0], 1'b0};
         sat_ff[s]  <= sat_prev;
         side_ff[s] <= side_prev;
      end
   end

   assign out_valid = v_ff[QUO_W-1];
   assign out_quo   = sat_ff[QUO_W-1] ? '1 : quo_ff[QUO_W-1];
   assign out_side  = side_ff[QUO_W-1];

endmodule

// ===== rtl/lod_level_select_dither_top.sv =====
// ---------------------------------------------------------------------------
// LOD level select with dither
// Projects a placement's bounding sphere to pixels and picks its level.
// ---------------------------------------------------------------------------
// channel   ports                        handshake
// request   req_* fields                 start high, busy low
// response  rsp_level, rsp_projected_px  rsp_valid strobe, one cycle
// config    csr_index, csr_data          csr_write
//
// One item per cycle; results leave in the order of their items.
// Depth is set by the square root and divider pipelines, one bit per stage.
// busy stays low; the response side cannot stall.
// Reset clears valid bits and loads register defaults.
// ---------------------------------------------------------------------------
`include "lod_level_select_dither_top_assert.svh"

module lod_level_select_dither_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [31:0] req_min_x,
   input  logic [31:0] req_min_y,
   input  logic [31:0] req_min_z,
   input  logic [31:0] req_max_x,
   input  logic [31:0] req_max_y,
   input  logic [31:0] req_max_z,
   input  logic [31:0] req_mesh_id,
   input  logic [31:0] req_placement_index,
   input  logic        req_keep_full,
   input  logic        csr_write,
   input  logic [2:0]  csr_index,
   input  logic [63:0] csr_data,
   output logic        rsp_valid,
   output logic [1:0]  rsp_level,
   output logic [31:0] rsp_projected_px
);
   import lodsel_pkg::*;

   logic [47:0] forward_dir_ff;
   logic [31:0] eye_depth_ff;
   logic [31:0] focal_px_ff;
   logic [31:0] near_plane_ff;
   logic [31:0] cull_px_ff;
   logic [63:0] full_band_ff;
   logic [31:0] dither_seed_ff;
   logic [1:0]  lod_mode_ff;

   logic              fr_valid;
   logic [SQ_W-1:0]   fr_dsq;
   side_type          fr_side;
   logic              sq_valid;
   logic [ROOT_W-1:0] sq_root;
   side_type          sq_side;

   logic              mul_v_ff;
   logic [NUM_W-1:0]  num_ff;
   side_type          mul_side_ff;

   logic              dv_valid;
   logic [QUO_W-1:0]  dv_px;
   side_type          dv_side;

   logic [31:0] lo;
   logic [31:0] hi;
   logic [31:0] span_raw;
   logic [31:0] span;

   logic        c_v_ff;
   logic [31:0] c_px_ff;
   logic [31:0] c_diff_ff;
   logic [55:0] c_dprod_ff;
   logic        c_forced_ff;
   logic        c_culled_ff;
   logic        c_noproxy_ff;
   logic        c_ge_hi_ff;
   logic        c_le_lo_ff;

   level_type   level_in;
   logic        rsp_valid_ff;
   level_type   rsp_level_ff;
   logic [31:0] rsp_px_ff;

   assign busy = 1'b0;

   always_ff @(posedge clock) begin
      if (reset) begin
         forward_dir_ff <= '0;
         eye_depth_ff   <= '0;
         focal_px_ff    <= FOCAL_RESET;
         near_plane_ff  <= NEAR_RESET;
         cull_px_ff     <= CULL_RESET;
         full_band_ff   <= '0;
         dither_seed_ff <= '0;
         lod_mode_ff    <= '0;
      end else if (csr_write) begin
         case (csr_index_type'(csr_index))
            CSR_FORWARD_DIR: forward_dir_ff <= csr_data[47:0];
            CSR_EYE_DEPTH:   eye_depth_ff   <= csr_data[31:0];
            CSR_FOCAL_PX:    focal_px_ff    <= csr_data[31:0];
            CSR_NEAR_PLANE:  near_plane_ff  <= csr_data[31:0];
            CSR_CULL_PX:     cull_px_ff     <= csr_data[31:0];
            CSR_FULL_BAND:   full_band_ff   <= csr_data;
            CSR_DITHER_SEED: dither_seed_ff <= csr_data[31:0];
            CSR_LOD_MODE:    lod_mode_ff    <= csr_data[1:0];
            default: ;
         endcase
      end
   end

   lodsel_front u_front (
      .clock           (clock),
      .reset           (reset),
      .in_valid        (start && !busy),
      .min_x           (req_min_x),
      .min_y           (req_min_y),
      .min_z           (req_min_z),
      .max_x           (req_max_x),
      .max_y           (req_max_y),
      .max_z           (req_max_z),
      .mesh_id         (req_mesh_id),
      .placement_index (req_placement_index),
      .keep_full       (req_keep_full),
      .forward_dir     (forward_dir_ff),
      .eye_depth       (eye_depth_ff),
      .near_plane      (near_plane_ff),
      .dither_seed     (dither_seed_ff),
      .out_valid       (fr_valid),
      .out_dsq         (fr_dsq),
      .out_side        (fr_side)
   );

   lodsel_isqrt u_isqrt (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (fr_valid),
      .in_value  (fr_dsq),
      .in_side   (fr_side),
      .out_valid (sq_valid),
      .out_root  (sq_root),
      .out_side  (sq_side)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         mul_v_ff <= 1'b0;
      end else begin
         mul_v_ff <= sq_valid;
      end
      num_ff      <= NUM_W'(focal_px_ff) * NUM_W'(sq_root);
      mul_side_ff <= sq_side;
   end

   lodsel_div u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (mul_v_ff),
      .in_num    (num_ff),
      .in_side   (mul_side_ff),
      .out_valid (dv_valid),
      .out_quo   (dv_px),
      .out_side  (dv_side)
   );

   always_comb begin
      lo       = full_band_ff[31:0];
      hi       = full_band_ff[63:32];
      span_raw = hi - lo;
      span     = (span_raw < MIN_SPAN) ? MIN_SPAN : span_raw;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c_v_ff <= 1'b0;
      end else begin
         c_v_ff <= dv_valid;
      end
      c_px_ff      <= dv_px;
      c_diff_ff    <= dv_px - lo;
      c_dprod_ff   <= 56'(dv_side.hash_hi) * 56'(span);
      c_forced_ff  <= dv_side.keep_full || !lod_mode_ff[0];
      c_culled_ff  <= dv_px < cull_px_ff;
      c_noproxy_ff <= !lod_mode_ff[1];
      c_ge_hi_ff   <= dv_px >= hi;
      c_le_lo_ff   <= dv_px <= lo;
   end

   always_comb begin
      if (c_forced_ff) begin
         level_in = LEVEL_FULL;
      end else if (c_culled_ff) begin
         level_in = LEVEL_CULLED;
      end else if (c_noproxy_ff || c_ge_hi_ff) begin
         level_in = LEVEL_FULL;
      end else if (c_le_lo_ff) begin
         level_in = LEVEL_PROXY;
      end else if (c_dprod_ff < {c_diff_ff, 24'd0}) begin
         level_in = LEVEL_FULL;
      end else begin
         level_in = LEVEL_PROXY;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= c_v_ff;
      end
      rsp_level_ff <= level_in;
      rsp_px_ff    <= c_px_ff;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_level        = rsp_level_ff;
   assign rsp_projected_px = rsp_px_ff;

   `LODSEL_ASSERT(a_rsp_follows_req, clock, reset, rsp_valid |-> $past(start, LATENCY))
   `LODSEL_ASSERT(a_cull_below_thr, clock, reset, (rsp_valid && rsp_level == LEVEL_CULLED) |-> (lod_mode_ff[0] && rsp_projected_px < cull_px_ff))
   `LODSEL_ASSERT(a_proxy_enabled, clock, reset, (rsp_valid && rsp_level == LEVEL_PROXY) |-> (lod_mode_ff == 2'b11))
   `LODSEL_ASSERT_ALWAYS(a_never_busy, clock, !busy)

endmodule

// ===== bench/lod_level_select_dither_checker.sv =====
// ---------------------------------------------------------------------------
// LOD select checker
// Watches the item and result channels, predicts each placement's level and
// projected radius from the register shadow, and compares in order.
// ---------------------------------------------------------------------------
module lod_level_select_dither_checker
   import lodsel_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic        busy,
   input  logic [31:0] req_min_x,
   input  logic [31:0] req_min_y,
   input  logic [31:0] req_min_z,
   input  logic [31:0] req_max_x,
   input  logic [31:0] req_max_y,
   input  logic [31:0] req_max_z,
   input  logic [31:0] req_mesh_id,
   input  logic [31:0] req_placement_index,
   input  logic        req_keep_full,
   input  logic        csr_write,
   input  logic [2:0]  csr_index,
   input  logic [63:0] csr_data,
   input  logic        rsp_valid,
   input  logic [1:0]  rsp_level,
   input  logic [31:0] rsp_projected_px,
   output int          fail_count,
   output int          pending_count,
   output int          result_count
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      level_type   level;
      logic [31:0] px;
   } pick_type;

   pick_type lod_picks[$];

   logic [47:0] fwd_q;
   logic signed [31:0] eye_q;
   logic [31:0] focal_q, near_q, cull_q, seed_q;
   logic [63:0] band_q;
   logic [1:0]  mode_q;

   assign pending_count = lod_picks.size();

   function automatic logic [63:0] int_sqrt(input logic [63:0] n);
      logic [63:0] root, bit_v, rem;
      root = 0;
      rem = n;
      bit_v = 64'd1 << 62;
      while (bit_v > rem) bit_v >>= 2;
      while (bit_v != 0) begin
         if (rem >= root + bit_v) begin
            rem -= root + bit_v;
            root = (root >> 1) + bit_v;
         end else begin
            root >>= 1;
         end
         bit_v >>= 2;
      end
      return root;
   endfunction

   function automatic logic [31:0] scramble(input logic [31:0] x);
      x ^= x >> 16;
      x *= 32'h7feb352d;
      x ^= x >> 15;
      x *= 32'h846ca68b;
      x ^= x >> 16;
      return x;
   endfunction

   function automatic pick_type pick_level(
      input logic [31:0] mn[3], input logic [31:0] mx[3],
      input logic [31:0] mesh, input logic [31:0] pidx, input logic keep);
      logic signed [63:0] d, dot, depth, a, b, f;
      logic [63:0] e, dsq, radius, nearv, px, lo, hi, span;
      logic [31:0] h;
      pick_type r;
      dsq = 0;
      dot = 0;
      for (int i = 0; i < 3; i++) begin
         a = 64'(signed'(mn[i]));
         b = 64'(signed'(mx[i]));
         d = b - a;
         e = 64'(d < 0 ? -d : d) >> 1;
         dsq += e * e;
         f = 64'(signed'(fwd_q[16*i +: 16]));
         dot += (a + b) * f;
      end
      radius = int_sqrt(dsq);
      depth = (dot >>> 16) - 64'(eye_q);
      nearv = (near_q != 0) ? 64'(near_q) : 64'd1;
      if (depth < signed'(nearv)) depth = signed'(nearv);
      px = (64'(focal_q) * radius) / 64'(depth);
      if (px > 64'hFFFF_FFFF) px = 64'hFFFF_FFFF;
      lo = 64'(band_q[31:0]);
      hi = 64'(band_q[63:32]);
      if (keep || !mode_q[0]) r.level = LEVEL_FULL;
      else if (px < 64'(cull_q)) r.level = LEVEL_CULLED;
      else if (!mode_q[1]) r.level = LEVEL_FULL;
      else if (px >= hi) r.level = LEVEL_FULL;
      else if (px <= lo) r.level = LEVEL_PROXY;
      else begin
         span = hi - lo;
         if (span < 64'(MIN_SPAN)) span = 64'(MIN_SPAN);
         h = scramble((mesh * 32'h9e3779b9) ^ (pidx + 32'd1) ^ seed_q);
         r.level = (64'(h >> 8) * span < ((px - lo) << 24)) ? LEVEL_FULL : LEVEL_PROXY;
      end
      r.px = px[31:0];
      return r;
   endfunction

   always @(posedge clock) begin
      pick_type want;
      logic [31:0] mn[3], mx[3];
      int errs;
      errs = 0;
      if (reset) begin
         fwd_q <= '0;
         eye_q <= '0;
         focal_q <= 32'h0001_0000;
         near_q <= 32'd6554;
         cull_q <= 32'h0001_0000;
         band_q <= '0;
         seed_q <= '0;
         mode_q <= '0;
         lod_picks.delete();
         fail_count <= 0;
         result_count <= 0;
      end else begin
         if (rsp_valid) begin
            result_count <= result_count + 1;
            if (lod_picks.size() == 0) begin
               $error("result with no item pending");
               errs++;
            end else begin
               want = lod_picks.pop_front();
               if (rsp_level !== want.level) begin
                  $error("level expected %0d actual %0d", want.level, rsp_level);
                  errs++;
               end
               if (rsp_projected_px !== want.px) begin
                  $error("projected_px expected %h actual %h", want.px, rsp_projected_px);
                  errs++;
               end
            end
         end
         fail_count <= fail_count + errs;
         if (start && !busy) begin
            mn = '{req_min_x, req_min_y, req_min_z};
            mx = '{req_max_x, req_max_y, req_max_z};
            lod_picks = {lod_picks, pick_level(mn, mx, req_mesh_id, req_placement_index,
                                               req_keep_full)};
         end
         if (csr_write) begin
            case (csr_index_type'(csr_index))
               CSR_FORWARD_DIR: fwd_q <= csr_data[47:0];
               CSR_EYE_DEPTH:   eye_q <= csr_data[31:0];
               CSR_FOCAL_PX:    focal_q <= csr_data[31:0];
               CSR_NEAR_PLANE:  near_q <= csr_data[31:0];
               CSR_CULL_PX:     cull_q <= csr_data[31:0];
               CSR_FULL_BAND:   band_q <= csr_data;
               CSR_DITHER_SEED: seed_q <= csr_data[31:0];
               CSR_LOD_MODE:    mode_q <= csr_data[1:0];
               default: ;
            endcase
         end
      end
   end
endmodule

// ===== bench/lod_level_select_dither_top_test.sv =====
// ---------------------------------------------------------------------------
// LOD select testbench
// Directed and random placements under several camera and band settings,
// with random start gaps; a checker predicts and compares every result.
// ---------------------------------------------------------------------------
module lod_level_select_dither_top_test;
   timeunit 1ns;
   timeprecision 1ps;
   import lodsel_pkg::*;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   logic [31:0] req_min_x, req_min_y, req_min_z, req_max_x, req_max_y, req_max_z;
   logic [31:0] req_mesh_id, req_placement_index;
   logic        req_keep_full;
   logic        csr_write;
   logic [2:0]  csr_index;
   logic [63:0] csr_data;
   logic        rsp_valid;
   logic [1:0]  rsp_level;
   logic [31:0] rsp_projected_px;
   int          fail_count, pending_count, result_count;
   bit          steady;

   lod_level_select_dither_top uut (.*);
   lod_level_select_dither_checker chk (.*);

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   initial begin
      #50ms;
      $display("DONE: errors detected");
      $finish;
   end

   task automatic write_reg(input csr_index_type idx, input logic [63:0] val);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
      csr_write <= 1'b0;
   endtask

   task automatic drain();
      while (pending_count != 0) @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);
   endtask

   task automatic send_box(input logic [31:0] b[6], input logic [31:0] mesh,
                           input logic [31:0] pidx, input logic keep);
      while (!steady && $urandom_range(99) < 19) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start <= 1'b1;
      {req_min_x, req_min_y, req_min_z} <= {b[0], b[1], b[2]};
      {req_max_x, req_max_y, req_max_z} <= {b[3], b[4], b[5]};
      req_mesh_id <= mesh;
      req_placement_index <= pidx;
      req_keep_full <= keep;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   // well-scaled box unless wild: center within 32 units on each axis, half extent up to 8 units
   task automatic send_random(input int wild);
      logic [31:0] b[6];
      logic signed [31:0] c, r;
      for (int i = 0; i < 6; i++) b[i] = $urandom;
      if (!wild) begin
         for (int i = 0; i < 3; i++) begin
            c = signed'($urandom_range(32'h0040_0000)) - 32'sh0020_0000;
            r = signed'($urandom_range(32'h0008_0000));
            b[i] = c - r;
            b[i+3] = c + r;
         end
      end
      send_box(b, $urandom, $urandom, $urandom_range(15) == 0);
   endtask

   task automatic set_camera(input int k);
      logic [63:0] lo, hi;
      write_reg(CSR_FORWARD_DIR, k == 0 ? 64'h7fff_0000_0000 : {$urandom, $urandom});
      write_reg(CSR_EYE_DEPTH, k == 1 ? 64'h8000_0000 : 64'(signed'($urandom_range(8)
                << 16) * -1));
      write_reg(CSR_FOCAL_PX, k == 2 ? 64'hFFFF_FFFF : 64'($urandom_range(32'h0400_0000)));
      write_reg(CSR_NEAR_PLANE, k == 3 ? 64'd0 : 64'($urandom_range(32'h0002_0000)));
      write_reg(CSR_CULL_PX, k == 4 ? 64'd0 : 64'($urandom_range(32'h0010_0000)));
      lo = $urandom_range(32'h0100_0000);
      hi = (k == 5) ? lo - 1 : lo + $urandom_range(32'h0200_0000);
      if (k == 6) hi = lo + 1;
      write_reg(CSR_FULL_BAND, {hi[31:0], lo[31:0]});
      write_reg(CSR_DITHER_SEED, $urandom);
      write_reg(CSR_LOD_MODE, k == 7 ? 64'd1 : 64'd3);
   endtask

   initial begin
      logic [31:0] b[6];
      reset = 1'b1;
      start = 1'b0;
      steady = 1'b0;
      csr_write = 1'b0;
      csr_index = '0;
      csr_data = '0;
      {req_min_x, req_min_y, req_min_z, req_max_x, req_max_y, req_max_z} = '0;
      req_mesh_id = '0;
      req_placement_index = '0;
      req_keep_full = 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset defaults: lod off, all full
      b = '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
            32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF};
      send_box(b, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
      b = '{32'h7FFF_FFFF, 0, 32'hFFFF_0000, 32'h8000_0000, 0, 32'h0001_0000};
      send_box(b, 0, 0, 1'b1);
      b = '{0, 0, 0, 0, 0, 0};
      send_box(b, 1, 2, 1'b0);
      start <= 1'b0;
      drain();

      for (int k = 0; k < 8; k++) begin
         set_camera(k);
         for (int n = 0; n < 3; n++) send_random(n == 2);
         start <= 1'b0;
         drain();
      end

      for (int p = 0; p < 12; p++) begin
         set_camera(p % 9);
         steady = (p == 4);
         for (int n = 0; n < 100; n++) send_random($urandom_range(9) == 0);
         if (p == 6) begin
            start <= 1'b0;
            while (pending_count != 0) @(posedge clock);
         end
         start <= 1'b0;
         drain();
      end

      $display("covered reset defaults, box extremes, eight register settings and");
      $display("%0d results with random start gaps", result_count);
      if (fail_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end
endmodule
